// ===== hdl/ewth_pkg.sv =====
package ewth_pkg;

  localparam int ROUNDTRIP_US_PER_CM = 57;

  localparam int TIME_W = 16;
  localparam int CM_W   = 9;
  localparam int DIST_W = 11;

  // Converted thresholds: 511 * 57 stays below 2^16
  localparam int THR_W = 16;

  // Distance = (4 * w) / R. At or above this width it saturates.
  localparam int DIST_SAT_W = 512 * ROUNDTRIP_US_PER_CM;
  localparam int DIST_MAX   = (1 << DIST_W) - 1;

  // Reciprocal for x = 4 * w below 2^17: floor(x / R) == (x * M) >> 23
  localparam int DIST_K     = 23;
  localparam int DIST_MULT  = ((1 << DIST_K) + ROUNDTRIP_US_PER_CM - 1) / ROUNDTRIP_US_PER_CM;
  localparam int DIST_SHIFT = DIST_K - 2;
  localparam int MULT_W     = 18;
  localparam int PROD_W     = TIME_W + MULT_W;

  typedef enum logic {
    CMD_EDGE       = 1'b0,
    CMD_PERIOD_END = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_NEAR_CM = 2'd0,
    REG_FAR_CM  = 2'd1,
    REG_NEAR_EN = 2'd2,
    REG_FAR_EN  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [THR_W-1:0] near_ticks;
    logic [THR_W-1:0] far_ticks;
    logic             near_en;
    logic             far_en;
  } thr_t;

  typedef struct packed {
    logic              near_hit;
    logic              far_hit;
    logic              width_updated;
    logic [TIME_W-1:0] echo_width;
  } meas_t;

endpackage

// ===== hdl/ewth_if.sv =====
interface ewth_in_if;
  import ewth_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [TIME_W-1:0] capture_time;

  modport source (output valid, output cmd, output capture_time, input ready);
  modport sink   (input valid, input cmd, input capture_time, output ready);
endinterface

interface ewth_out_if;
  import ewth_pkg::*;

  logic              valid;
  logic              ready;
  logic              near_hit;
  logic              far_hit;
  logic              width_updated;
  logic [TIME_W-1:0] echo_width;
  logic [DIST_W-1:0] distance_cm;

  modport source (output valid, output near_hit, output far_hit, output width_updated,
                  output echo_width, output distance_cm, input ready);
  modport sink   (input valid, input near_hit, input far_hit, input width_updated,
                  input echo_width, input distance_cm, output ready);
endinterface

// ===== hdl/ewth_cfg.sv =====
module ewth_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [ewth_pkg::CM_W-1:0]    cfg_wdata_i,
  output ewth_pkg::thr_t               thr_o
);
  import ewth_pkg::*;

  logic [CM_W-1:0] near_cm_q, far_cm_q;
  logic            near_en_q, far_en_q;
  thr_t            thr_q, thr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_cm_q <= '0;
      far_cm_q  <= '0;
      near_en_q <= 1'b0;
      far_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NEAR_CM: near_cm_q <= cfg_wdata_i;
        REG_FAR_CM:  far_cm_q  <= cfg_wdata_i;
        REG_NEAR_EN: near_en_q <= cfg_wdata_i[0];
        REG_FAR_EN:  far_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Convert centimetres to timer ticks once, off the item path
  always_comb begin
    thr_d.near_ticks = THR_W'((THR_W'(near_cm_q) * THR_W'(ROUNDTRIP_US_PER_CM)) >> 2);
    thr_d.far_ticks  = THR_W'((THR_W'(far_cm_q) * THR_W'(ROUNDTRIP_US_PER_CM)) >> 2);
    thr_d.near_en    = near_en_q;
    thr_d.far_en     = far_en_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign thr_o = thr_q;

endmodule

// ===== hdl/ewth_meas.sv =====
module ewth_meas (
  input  logic            clk_i,
  input  logic            rst_ni,
  ewth_in_if.sink         req_i,
  input  ewth_pkg::thr_t  thr_i,
  output logic            meas_valid_o,
  input  logic            meas_ready_i,
  output ewth_pkg::meas_t meas_o
);
  import ewth_pkg::*;

  // Input register
  logic              s1_valid_q;
  cmd_e              s1_cmd_q;
  logic [TIME_W-1:0] s1_time_q;

  // Measurement state
  logic              echo_high_q, echo_high_d;
  logic [TIME_W-1:0] rise_time_q, rise_time_d;
  logic [TIME_W-1:0] stored_width_q, stored_width_d;
  logic              measure_valid_q, measure_valid_d;
  logic              near_armed_q, near_armed_d;

  // Result register flags
  logic              s2_valid_q;
  logic              near_hit_q, near_hit_d;
  logic              far_hit_q, far_hit_d;
  logic              upd_q, upd_d;

  logic              s2_ready, s1_ready;
  logic              s1_adv;
  logic [TIME_W-1:0] width;
  logic              armed_mid;

  assign s2_ready    = !s2_valid_q || meas_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign s1_adv      = s1_valid_q && s2_ready;
  assign req_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && req_i.valid) begin
      s1_cmd_q  <= cmd_e'(req_i.cmd);
      s1_time_q <= req_i.capture_time;
    end
  end

  assign width = s1_time_q - rise_time_q;

  always_comb begin
    echo_high_d     = echo_high_q;
    rise_time_d     = rise_time_q;
    stored_width_d  = stored_width_q;
    measure_valid_d = measure_valid_q;
    near_armed_d    = near_armed_q;
    near_hit_d      = 1'b0;
    far_hit_d       = 1'b0;
    upd_d           = 1'b0;
    armed_mid       = near_armed_q;

    if (s1_cmd_q == CMD_PERIOD_END) begin
      if (echo_high_q) begin
        measure_valid_d = 1'b0;
      end
    end else if (!echo_high_q) begin
      rise_time_d = s1_time_q;
      echo_high_d = 1'b1;
    end else begin
      if (!measure_valid_q) begin
        // drop the invalidated measurement and recover
        measure_valid_d = 1'b1;
      end else begin
        stored_width_d = width;
        upd_d          = 1'b1;
        if (thr_i.near_en && near_armed_q && (width < thr_i.near_ticks)) begin
          near_hit_d = 1'b1;
          if (thr_i.far_en) begin
            armed_mid = 1'b0;
          end
        end
        // far check sees the near decision of this same edge
        if (thr_i.far_en && !armed_mid && (width > thr_i.far_ticks)) begin
          far_hit_d = 1'b1;
          armed_mid = 1'b1;
        end
        near_armed_d = armed_mid;
      end
      echo_high_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_high_q     <= 1'b0;
      rise_time_q     <= '0;
      stored_width_q  <= '0;
      measure_valid_q <= 1'b0;
      near_armed_q    <= 1'b1;
      s2_valid_q      <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        echo_high_q     <= echo_high_d;
        rise_time_q     <= rise_time_d;
        stored_width_q  <= stored_width_d;
        measure_valid_q <= measure_valid_d;
        near_armed_q    <= near_armed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      near_hit_q <= near_hit_d;
      far_hit_q  <= far_hit_d;
      upd_q      <= upd_d;
    end
  end

  // stored width only moves when this stage reloads, so it is the item's width
  assign meas_valid_o         = s2_valid_q;
  assign meas_o.near_hit      = near_hit_q;
  assign meas_o.far_hit       = far_hit_q;
  assign meas_o.width_updated = upd_q;
  assign meas_o.echo_width    = stored_width_q;

endmodule

// ===== hdl/ewth_dist.sv =====
module ewth_dist (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            meas_valid_i,
  output logic            meas_ready_o,
  input  ewth_pkg::meas_t meas_i,
  ewth_out_if.source      rsp_o
);
  import ewth_pkg::*;

  logic              out_valid_q;
  meas_t             meas_q;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [PROD_W-1:0] prod;
  logic              ready;

  assign ready        = !out_valid_q || rsp_o.ready;
  assign meas_ready_o = ready;

  assign prod = PROD_W'(meas_i.echo_width) * PROD_W'(DIST_MULT);

  always_comb begin
    if (meas_i.echo_width >= TIME_W'(DIST_SAT_W)) begin
      dist_d = DIST_W'(DIST_MAX);
    end else begin
      dist_d = DIST_W'(prod >> DIST_SHIFT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready) begin
      out_valid_q <= meas_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && meas_valid_i) begin
      meas_q <= meas_i;
      dist_q <= dist_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.near_hit      = meas_q.near_hit;
  assign rsp_o.far_hit       = meas_q.far_hit;
  assign rsp_o.width_updated = meas_q.width_updated;
  assign rsp_o.echo_width    = meas_q.echo_width;
  assign rsp_o.distance_cm   = dist_q;

endmodule

// ===== hdl/echo_width_threshold_hysteresis_core.sv =====
// Path: a request passes the input register, the measurement register and
// the distance register in order, and each holds one item.
// Throughput: one request per cycle unless the output stalls; the
// registers stall together.
// Reset: asynchronous, active low; clears handshake state, measurement state
// and the configuration, and arms the near check.
module echo_width_threshold_hysteresis_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ewth_in_if.sink                   req_i,
  ewth_out_if.source                rsp_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [ewth_pkg::CM_W-1:0] cfg_wdata_i
);
  import ewth_pkg::*;

  thr_t  thr;
  meas_t meas;
  logic  meas_valid;
  logic  meas_ready;

  ewth_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .thr_o       (thr)
  );

  ewth_meas u_meas (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .thr_i        (thr),
    .meas_valid_o (meas_valid),
    .meas_ready_i (meas_ready),
    .meas_o       (meas)
  );

  ewth_dist u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .meas_valid_i (meas_valid),
    .meas_ready_o (meas_ready),
    .meas_i       (meas),
    .rsp_o        (rsp_o)
  );

endmodule

// ===== hdl/ewth_checker.sv =====
module ewth_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        near_hit_i,
  input logic                        far_hit_i,
  input logic                        width_updated_i,
  input logic [ewth_pkg::TIME_W-1:0] echo_width_i,
  input logic [ewth_pkg::DIST_W-1:0] distance_cm_i
);
  import ewth_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(echo_width_i) && $stable(distance_cm_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !width_updated_i |-> !near_hit_i && !far_hit_i)
    else $error("threshold hit without a new width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (echo_width_i < TIME_W'(DIST_SAT_W)) |->
      (32'(distance_cm_i) * ROUNDTRIP_US_PER_CM <= 32'(echo_width_i) * 4) &&
      (32'(echo_width_i) * 4 < (32'(distance_cm_i) + 1) * ROUNDTRIP_US_PER_CM))
    else $error("distance does not match width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (echo_width_i >= TIME_W'(DIST_SAT_W)) |->
      distance_cm_i == DIST_W'(DIST_MAX))
    else $error("distance not saturated");

endmodule

bind echo_width_threshold_hysteresis_core ewth_checker u_ewth_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .near_hit_i      (rsp_o.near_hit),
  .far_hit_i       (rsp_o.far_hit),
  .width_updated_i (rsp_o.width_updated),
  .echo_width_i    (rsp_o.echo_width),
  .distance_cm_i   (rsp_o.distance_cm)
);

// ===== test/echo_width_threshold_hysteresis_core_test.sv =====
`timescale 1ns / 100ps

module echo_width_threshold_hysteresis_core_test;
  import ewth_pkg::*;

  typedef struct packed {
    cmd_e              cmd;
    logic [TIME_W-1:0] stamp;
  } capture_t;

  typedef struct packed {
    logic              near_hit;
    logic              far_hit;
    logic              width_updated;
    logic [TIME_W-1:0] echo_width;
    logic [DIST_W-1:0] distance_cm;
  } echo_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [CM_W-1:0] cfg_wdata_i;

  ewth_in_if  req_if ();
  ewth_out_if rsp_if ();

  echo_width_threshold_hysteresis_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  capture_t     capture_queue[$];
  echo_result_t expected_meas[$];
  int           mismatches = 0;
  bit           calm = 1'b0;
  bit           gen_high = 1'b0;
  int           send_gap = 0;
  int           recv_gap = 0;

  // Register copy
  logic [CM_W-1:0] cfg_near_cm = '0;
  logic [CM_W-1:0] cfg_far_cm  = '0;
  logic            cfg_near_en = 1'b0;
  logic            cfg_far_en  = 1'b0;

  // Measurement state copy
  logic              m_echo_high = 1'b0;
  logic [TIME_W-1:0] m_rise      = '0;
  logic [TIME_W-1:0] m_width     = '0;
  logic              m_valid     = 1'b0;
  logic              m_near_armed = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [TIME_W-1:0] ticks_of(logic [CM_W-1:0] cm);
    int v;
    v = cm;
    v = (v * ROUNDTRIP_US_PER_CM) >> 2;
    return v[TIME_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] dist_of(logic [TIME_W-1:0] w);
    int d;
    d = w;
    d = (d * 4) / ROUNDTRIP_US_PER_CM;
    if (d > 2047) d = 2047;
    return d[DIST_W-1:0];
  endfunction

  function automatic echo_result_t echo_measure(cmd_e c, logic [TIME_W-1:0] t);
    echo_result_t r;
    logic [TIME_W-1:0] w;
    r = '0;
    if (c == CMD_PERIOD_END) begin
      if (m_echo_high) m_valid = 1'b0;
    end else if (!m_echo_high) begin
      m_rise = t;
      m_echo_high = 1'b1;
    end else begin
      if (!m_valid) begin
        m_valid = 1'b1;
      end else begin
        w = t - m_rise;
        m_width = w;
        r.width_updated = 1'b1;
        if (cfg_near_en && m_near_armed && w < ticks_of(cfg_near_cm)) begin
          r.near_hit = 1'b1;
          if (cfg_far_en) m_near_armed = 1'b0;
        end
        // a near hit may disarm and re-arm within the same width
        if (cfg_far_en && !m_near_armed && w > ticks_of(cfg_far_cm)) begin
          r.far_hit = 1'b1;
          m_near_armed = 1'b1;
        end
      end
      m_echo_high = 1'b0;
    end
    r.echo_width = m_width;
    r.distance_cm = dist_of(m_width);
    return r;
  endfunction

  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Request driver
  always @(posedge clk_i) begin
    capture_t item;
    if (rst_ni) begin
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (capture_queue.size() > 0) begin
          item = capture_queue.pop_front();
          req_if.valid <= 1'b1;
          req_if.cmd <= item.cmd;
          req_if.capture_time <= item.stamp;
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 11);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: predict on each accepted request, then check each result
  always @(posedge clk_i) begin
    echo_result_t want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        expected_meas.push_back(echo_measure(cmd_e'(req_if.cmd), req_if.capture_time));
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_meas.size() == 0) begin
          $display("%0t: result with none expected, got width %0d", $time,
                   rsp_if.echo_width);
          mismatches++;
        end else begin
          want = expected_meas.pop_front();
          compare_field("near_hit", want.near_hit, rsp_if.near_hit);
          compare_field("far_hit", want.far_hit, rsp_if.far_hit);
          compare_field("width_updated", want.width_updated, rsp_if.width_updated);
          compare_field("echo_width", want.echo_width, rsp_if.echo_width);
          compare_field("distance_cm", want.distance_cm, rsp_if.distance_cm);
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 11);
      end
    end
  end

  task automatic queue_req(cmd_e c, logic [TIME_W-1:0] t);
    capture_t item;
    item.cmd = c;
    item.stamp = t;
    capture_queue.push_back(item);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CM_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_NEAR_CM: cfg_near_cm = data;
      REG_FAR_CM:  cfg_far_cm = data;
      REG_NEAR_EN: cfg_near_en = data[0];
      REG_FAR_EN:  cfg_far_en = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (capture_queue.size() != 0 || expected_meas.size() != 0 || req_if.valid);
  endtask

  task automatic set_thresholds(logic [CM_W-1:0] near, logic [CM_W-1:0] far,
                                logic ne, logic fe);
    wait_drained();
    write_reg(REG_NEAR_CM, near);
    write_reg(REG_FAR_CM, far);
    // upper data bits must be ignored by the enable registers
    write_reg(REG_NEAR_EN, {8'($urandom), ne});
    write_reg(REG_FAR_EN, {8'($urandom), fe});
    @(negedge clk_i);
  endtask

  function automatic logic [TIME_W-1:0] pick_width();
    case ($urandom_range(0, 4))
      0: return 16'(ticks_of(cfg_near_cm) + $urandom_range(0, 4) - 2);
      1: return 16'(ticks_of(cfg_far_cm) + $urandom_range(0, 4) - 2);
      2: return 16'($urandom_range(0, 64));
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 36000));
    endcase
  endfunction

  task automatic queue_random(int n);
    int k;
    int pick;
    logic [TIME_W-1:0] rise;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        // realign onto a rising edge first
        if (gen_high) begin
          queue_req(CMD_EDGE, 16'($urandom));
          k++;
        end
        rise = 16'($urandom);
        queue_req(CMD_EDGE, rise);
        if ($urandom_range(0, 9) == 0) begin
          queue_req(CMD_PERIOD_END, 16'($urandom));
          k++;
        end
        queue_req(CMD_EDGE, rise + pick_width());
        gen_high = 1'b0;
        k += 2;
      end else if (pick < 96) begin
        queue_req(CMD_PERIOD_END, 16'($urandom));
        k++;
      end else begin
        queue_req(CMD_EDGE, 16'($urandom));
        gen_high = !gen_high;
        k++;
      end
    end
  endtask

  initial begin
    int p;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_NEAR_CM;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_EDGE;
    req_if.capture_time = '0;
    rsp_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: first width dropped, wrap, invalidated period, saturation
    queue_req(CMD_EDGE, 16'h0000);
    queue_req(CMD_EDGE, 16'h0010);
    queue_req(CMD_EDGE, 16'hFFFF);
    queue_req(CMD_EDGE, 16'h0000);
    queue_req(CMD_PERIOD_END, 16'h1234);
    queue_req(CMD_EDGE, 16'h1000);
    queue_req(CMD_PERIOD_END, 16'hFFFF);
    queue_req(CMD_EDGE, 16'h2000);
    queue_req(CMD_EDGE, 16'h0000);
    queue_req(CMD_EDGE, 16'hFFFF);
    queue_req(CMD_PERIOD_END, 16'h0000);

    // Hysteresis: near hit disarms, far width re-arms
    set_thresholds(9'd500, 9'd511, 1'b1, 1'b1);
    queue_req(CMD_EDGE, 16'h0000);
    queue_req(CMD_EDGE, 16'd100);
    queue_req(CMD_EDGE, 16'h0000);
    queue_req(CMD_EDGE, 16'd100);
    queue_req(CMD_EDGE, 16'h8000);
    queue_req(CMD_EDGE, 16'h8000 + 16'd8000);
    queue_req(CMD_EDGE, 16'h0000);
    queue_req(CMD_EDGE, 16'd5);

    // Zero far threshold: near and far hit on the same width
    set_thresholds(9'd500, 9'd0, 1'b1, 1'b1);
    queue_req(CMD_EDGE, 16'h0000);
    queue_req(CMD_EDGE, 16'h0000);
    queue_req(CMD_EDGE, 16'h0000);
    queue_req(CMD_EDGE, 16'd1);
    queue_req(CMD_EDGE, 16'h0000);
    queue_req(CMD_EDGE, 16'd1);

    set_thresholds(9'd511, 9'd0, 1'b1, 1'b1);
    queue_random(144);
    set_thresholds(9'd0, 9'd511, 1'b1, 1'b1);
    queue_random(144);
    set_thresholds(9'd500, 9'd500, 1'b1, 1'b0);
    queue_random(144);
    set_thresholds(9'($urandom), 9'($urandom), 1'b0, 1'b1);
    queue_random(144);
    for (p = 0; p < 3; p++) begin
      set_thresholds(9'($urandom), 9'($urandom), 1'($urandom), 1'($urandom));
      queue_random(144);
    end
    // last stretch runs without idling on either side
    set_thresholds(9'($urandom_range(100, 511)), 9'($urandom_range(0, 300)), 1'b1, 1'b1);
    calm = 1'b1;
    queue_random(144);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
